FILE: rtl/mips_hi_lo_reloc_patcher_unit_macros.svh
// Assertion macros shared by the relocation patcher modules.
`ifndef MIPS_HI_LO_RELOC_PATCHER_UNIT_MACROS_SVH
`define MIPS_HI_LO_RELOC_PATCHER_UNIT_MACROS_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low.
`define MHLR_ASSERT_IMP(lbl, cond, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("mhlr: same-cycle check failed");

// Next-cycle implication, clocked on clk, off while rst_n is low.
`define MHLR_ASSERT_NXT(lbl, cond, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("mhlr: next-cycle check failed");

`endif

FILE: rtl/mhlr_pkg.sv
// Shared types and constants of the HI16/LO16 relocation patcher.
package mhlr_pkg;

    localparam int QUEUE_DEPTH    = 16;
    localparam int CNT_W          = $clog2(QUEUE_DEPTH + 1);
    localparam int IDX_W          = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    localparam int CMD_FIFO_DEPTH = 2;
    localparam int CMD_PTR_W      = (CMD_FIFO_DEPTH > 1) ? $clog2(CMD_FIFO_DEPTH) : 1;
    localparam int CMD_CNT_W      = $clog2(CMD_FIFO_DEPTH + 1);

    typedef enum logic {
        REQ_HI16 = 1'b0,
        REQ_LO16 = 1'b1
    } req_kind_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_MISMATCH = 2'd1,
        STATUS_OVERFLOW = 2'd2
    } status_t;

    // Classified request handed from front to back.
    typedef struct packed {
        req_kind_t   kind;
        logic [31:0] word;
        logic [31:0] addr;
        logic [31:0] target;
    } cmd_t;

endpackage

FILE: rtl/mhlr_front.sv
// Front end: accepts requests, forms the target value and classifies them.
module mhlr_front
    import mhlr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               req_type,
    input  logic [31:0]        insn_word,
    input  logic [31:0]        location,
    input  logic [31:0]        sym_address,
    input  logic signed [31:0] addend_value,
    output logic               cmd_valid,
    input  logic               cmd_ready,
    output cmd_t               cmd
);

    logic valid_reg;
    cmd_t cmd_reg;
    logic take;

    assign in_ready  = !valid_reg || cmd_ready;
    assign take      = in_valid && in_ready;
    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= 1'b1;
        end
        else if (cmd_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    // target wraps modulo 2^32
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cmd_reg.kind   <= req_kind_t'(req_type);
            cmd_reg.word   <= insn_word;
            cmd_reg.addr   <= location;
            cmd_reg.target <= sym_address + $unsigned(addend_value);
        end
    end

endmodule

FILE: rtl/mhlr_cmd_fifo.sv
// Short command queue between the front end and the patch sequencer.
module mhlr_cmd_fifo
    import mhlr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_valid,
    output logic wr_ready,
    input  cmd_t wr_cmd,
    output logic rd_valid,
    input  logic rd_ready,
    output cmd_t rd_cmd
);

    cmd_t                 slot_reg [CMD_FIFO_DEPTH];
    logic [CMD_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMD_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMD_CNT_W-1:0] fill_reg, fill_next;
    logic                 push, pop;

    assign wr_ready = (fill_reg != CMD_CNT_W'(CMD_FIFO_DEPTH));
    assign rd_valid = (fill_reg != '0);
    assign rd_cmd   = slot_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == CMD_PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0
                                                                         : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == CMD_PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0
                                                                         : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + CMD_CNT_W'(1);
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - CMD_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

FILE: rtl/mhlr_back.sv
// Back end: pending HI16 store, drain sequencer and output register.
`include "mips_hi_lo_reloc_patcher_unit_macros.svh"

module mhlr_back
    import mhlr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    output logic        cmd_ready,
    input  cmd_t        cmd,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] patch_address,
    output logic [31:0] patched_word,
    output logic        patch_valid,
    output logic [1:0]  status,
    output logic        last
);

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_DRAIN = 2'b10
    } state_t;

    typedef struct packed {
        logic [31:0] addr;
        logic [31:0] word;
        logic [31:0] value;
    } pend_entry_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;

    pend_entry_t        pend_mem [QUEUE_DEPTH];
    pend_entry_t        rd_reg;
    logic               wr_en;

    logic               out_valid_reg;
    logic [31:0]        addr_reg, word_reg;
    logic               pv_reg, last_reg;
    status_t            status_reg;

    logic               out_free;
    logic               emit;
    logic               drain_done;
    logic [31:0]        emit_addr, emit_word;
    logic               emit_pv, emit_last;
    status_t            emit_status;

    logic [31:0]        vallo;
    logic [31:0]        hi_sum;
    logic [15:0]        hi_half;
    logic [31:0]        lo_sum;

    assign out_free = !out_valid_reg || out_ready;
    assign vallo    = {{16{cmd.word[15]}}, cmd.word[15:0]};
    // HI16 value rounded with the carry out of bit 15
    assign hi_sum   = {rd_reg.word[15:0], 16'h0000} + vallo + cmd.target;
    assign hi_half  = hi_sum[31:16] + {15'd0, hi_sum[15]};
    assign lo_sum   = cmd.target + vallo;

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        cmd_ready   = 1'b0;
        wr_en       = 1'b0;
        emit        = 1'b0;
        drain_done  = 1'b0;
        emit_addr   = cmd.addr;
        emit_word   = '0;
        emit_pv     = 1'b0;
        emit_status = STATUS_OK;
        emit_last   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd.kind == REQ_HI16)
                    begin
                        if (count_reg == CNT_W'(QUEUE_DEPTH))
                        begin
                            // queue full: drop with a status-only result
                            if (out_free)
                            begin
                                emit        = 1'b1;
                                emit_status = STATUS_OVERFLOW;
                                emit_last   = 1'b1;
                                cmd_ready   = 1'b1;
                            end
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                            cmd_ready  = 1'b1;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        if (out_free)
                        begin
                            emit      = 1'b1;
                            emit_word = {cmd.word[31:16], lo_sum[15:0]};
                            emit_pv   = 1'b1;
                            emit_last = 1'b1;
                            cmd_ready = 1'b1;
                        end
                    end
                    else
                    begin
                        state_next = ST_DRAIN;
                        idx_next   = '0;
                    end
                end
            end
            ST_DRAIN:
            begin
                if (out_free)
                begin
                    emit        = 1'b1;
                    emit_addr   = rd_reg.addr;
                    emit_word   = {rd_reg.word[31:16], hi_half};
                    emit_pv     = 1'b1;
                    emit_status = (rd_reg.value != cmd.target) ? STATUS_MISMATCH
                                                               : STATUS_OK;
                    if (CNT_W'(idx_reg) + CNT_W'(1) == count_reg)
                    begin
                        // LO16 result follows from IDLE with the queue empty
                        drain_done = 1'b1;
                        count_next = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // pending store; read data registered from idx_next so it matches idx_reg
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            pend_mem[count_reg[IDX_W-1:0]] <= '{addr: cmd.addr, word: cmd.word,
                                                value: cmd.target};
        end
        rd_reg <= pend_mem[idx_next];
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            addr_reg   <= emit_addr;
            word_reg   <= emit_word;
            pv_reg     <= emit_pv;
            status_reg <= emit_status;
            last_reg   <= emit_last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign patch_address = addr_reg;
    assign patched_word  = word_reg;
    assign patch_valid   = pv_reg;
    assign status        = status_reg;
    assign last          = last_reg;

    `MHLR_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CNT_W'(QUEUE_DEPTH))
    `MHLR_ASSERT_IMP(a_drain_idx, state_reg == ST_DRAIN, CNT_W'(idx_reg) < count_reg)
    `MHLR_ASSERT_IMP(a_no_overwrite, emit, out_free)
    `MHLR_ASSERT_NXT(a_drain_empties, drain_done, count_reg == '0 && state_reg == ST_IDLE)

endmodule

FILE: rtl/mips_hi_lo_reloc_patcher_unit.sv
// Top level of the MIPS HI16/LO16 relocation patcher.
//
// Requests enter on in_valid/in_ready with req_type, insn_word, location,
// sym_address and addend_value; results leave on out_valid/out_ready with
// patch_address, patched_word, patch_valid, status and last.
// A HI16 request is stored in a 16-entry pending store and gives no result;
// when the store is full it is dropped with one overflow result.
// A LO16 request gives one result per pending HI16 entry, oldest first,
// then its own patched word with last set; the store is then empty.
// A result passes the front register, the command queue and the output
// register before out_valid; a LO16 with entries pending first reads the
// oldest entry from the store into a register.
// Throughput: one HI16 request per cycle unless a drain or a stalled
// output holds the sequencer. A LO16 request with entries pending holds
// the sequencer to start the store read, emit each entry through the
// single read port and emit its own word; with none pending, only its own.
// A two-entry command queue lets the front keep accepting while a drain runs.
// Reset clears the pending count, the queue and all valid flags; no results
// are lost or repeated while out_ready is low, the output register just holds.
module mips_hi_lo_reloc_patcher_unit
    import mhlr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               req_type,
    input  logic [31:0]        insn_word,
    input  logic [31:0]        location,
    input  logic [31:0]        sym_address,
    input  logic signed [31:0] addend_value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [31:0]        patch_address,
    output logic [31:0]        patched_word,
    output logic               patch_valid,
    output logic [1:0]         status,
    output logic               last
);

    // front -> queue
    logic front_valid, front_ready;
    cmd_t front_cmd;
    // queue -> sequencer
    logic seq_valid, seq_ready;
    cmd_t seq_cmd;

    mhlr_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .insn_word    (insn_word),
        .location     (location),
        .sym_address  (sym_address),
        .addend_value (addend_value),
        .cmd_valid    (front_valid),
        .cmd_ready    (front_ready),
        .cmd          (front_cmd)
    );

    mhlr_cmd_fifo u_cmd_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (front_valid),
        .wr_ready (front_ready),
        .wr_cmd   (front_cmd),
        .rd_valid (seq_valid),
        .rd_ready (seq_ready),
        .rd_cmd   (seq_cmd)
    );

    mhlr_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (seq_valid),
        .cmd_ready     (seq_ready),
        .cmd           (seq_cmd),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .patch_address (patch_address),
        .patched_word  (patched_word),
        .patch_valid   (patch_valid),
        .status        (status),
        .last          (last)
    );

endmodule

FILE: verif/tb.sv
// Self-checking testbench for the MIPS HI16/LO16 relocation patcher unit.
`default_nettype none

module tb
    import mhlr_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    // One write-back (or status-only) result as it leaves the unit.
    typedef struct packed {
        logic [31:0] addr;
        logic [31:0] word;
        logic        valid;
        status_t     st;
        logic        fin;
    } patch_t;

    // Tracks the pending HI16 store and the patches each request must produce.
    class reloc_scoreboard;
        logic [31:0] hi_addr[$];
        logic [31:0] hi_word[$];
        logic [31:0] hi_value[$];
        patch_t      expected_patches[$];
        int          errors;

        function new();
            errors = 0;
        endfunction

        function int outstanding();
            return expected_patches.size();
        endfunction

        // Called once per accepted request; appends the patches it causes.
        function void note_request(req_kind_t kind, logic [31:0] word, logic [31:0] loc,
                                   logic [31:0] sym, logic signed [31:0] addend);
            logic [31:0] target;
            logic [31:0] vallo;
            logic [31:0] sum;
            logic [15:0] hi;
            patch_t      p;
            target = sym + addend;
            if (kind == REQ_HI16) begin
                if (hi_addr.size() >= QUEUE_DEPTH) begin
                    p.addr  = loc;
                    p.word  = '0;
                    p.valid = 1'b0;
                    p.st    = STATUS_OVERFLOW;
                    p.fin   = 1'b1;
                    expected_patches.push_back(p);
                end
                else begin
                    hi_addr.push_back(loc);
                    hi_word.push_back(word);
                    hi_value.push_back(target);
                end
            end
            else begin
                vallo = {{16{word[15]}}, word[15:0]};
                while (hi_addr.size() != 0) begin
                    p.addr  = hi_addr.pop_front();
                    p.word  = hi_word.pop_front();
                    sum     = {p.word[15:0], 16'h0000} + vallo + target;
                    // Round the upper half by the carry out of bit 15.
                    hi      = sum[31:16] + {15'd0, sum[15]};
                    p.word  = {p.word[31:16], hi};
                    p.valid = 1'b1;
                    p.st    = (hi_value.pop_front() != target) ? STATUS_MISMATCH : STATUS_OK;
                    p.fin   = 1'b0;
                    expected_patches.push_back(p);
                end
                sum     = target + vallo;
                p.addr  = loc;
                p.word  = {word[31:16], sum[15:0]};
                p.valid = 1'b1;
                p.st    = STATUS_OK;
                p.fin   = 1'b1;
                expected_patches.push_back(p);
            end
        endfunction

        // Called once per accepted result; compares with the oldest expectation.
        function void check_patch(patch_t got);
            patch_t want;
            if (expected_patches.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: addr=%h word=%h pv=%0d st=%0d last=%0d",
                             got.addr, got.word, got.valid, got.st, got.fin);
                return;
            end
            want = expected_patches.pop_front();
            if (got.addr !== want.addr || got.word !== want.word || got.valid !== want.valid
                || got.st !== want.st || got.fin !== want.fin) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp addr=%h word=%h pv=%0d st=%0d last=%0d",
                             want.addr, want.word, want.valid, want.st, want.fin,
                             " | got addr=%h word=%h pv=%0d st=%0d last=%0d",
                             got.addr, got.word, got.valid, got.st, got.fin);
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic               req_type;
    logic [31:0]        insn_word;
    logic [31:0]        location;
    logic [31:0]        sym_address;
    logic signed [31:0] addend_value;
    logic               out_valid;
    logic               out_ready;
    logic [31:0]        patch_address;
    logic [31:0]        patched_word;
    logic               patch_valid;
    logic [1:0]         status;
    logic               last;

    reloc_scoreboard sb;
    int              sent_count;
    // When set, that side runs back to back with no idle cycles.
    bit              send_burst;
    bit              recv_burst;

    mips_hi_lo_reloc_patcher_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .insn_word    (insn_word),
        .location     (location),
        .sym_address  (sym_address),
        .addend_value (addend_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .patch_address(patch_address),
        .patched_word (patched_word),
        .patch_valid  (patch_valid),
        .status       (status),
        .last         (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case the unit hangs; far beyond the slowest legal run.
    initial
    begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Present one request after a random gap and hold it until accepted.
    // Signals are sampled right at the edge, so in_ready is the pre-edge value.
    task automatic send_request(req_kind_t kind, logic [31:0] word, logic [31:0] loc,
                                logic [31:0] sym, logic signed [31:0] addend);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        req_type     <= kind;
        insn_word    <= word;
        location     <= loc;
        sym_address  <= sym;
        addend_value <= addend;
        do @(posedge clk); while (!in_ready);
        sb.note_request(kind, word, loc, sym, addend);
        sent_count++;
    endtask

    // Stop sending and let every predicted result come out first.
    task automatic hold_until_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() != 0) @(posedge clk);
    endtask

    // Result side: random back-pressure, then check each accepted result.
    initial
    begin
        int     stall;
        patch_t got;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = recv_burst ? 0 : $urandom_range(0, 10);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            got.addr  = patch_address;
            got.word  = patched_word;
            got.valid = patch_valid;
            got.st    = status_t'(status);
            got.fin   = last;
            sb.check_patch(got);
        end
    end

    // Request side: reset, directed cases, then random relocation sequences.
    initial
    begin
        logic [31:0]        tgt;
        logic [31:0]        sym;
        logic [31:0]        word;
        logic signed [31:0] add;
        int                 n;
        int                 pick;

        sb           = new();
        sent_count   = 0;
        send_burst   = 1'b0;
        recv_burst   = 1'b0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        req_type     = REQ_HI16;
        insn_word    = '0;
        location     = '0;
        sym_address  = '0;
        addend_value = '0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // LO16 on an empty store: only its own patch, incl. wrap of sym + addend.
        send_request(REQ_LO16, 32'hffff_ffff, 32'hffff_fffc, 32'hffff_ffff, 32'sh7fff_ffff);
        send_request(REQ_LO16, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'sh0000_0000);
        send_request(REQ_LO16, 32'h0000_8000, 32'h8000_0000, 32'h0000_0000, 32'sh8000_0000);

        // Fill the store with one target split in different ways; low halves at
        // their extremes; one entry carries a different target (mismatch flag).
        tgt = 32'h1234_8000;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            word = $urandom;
            case (i)
                0: word[15:0] = 16'h0000;
                1: word[15:0] = 16'hffff;
                2: word[15:0] = 16'h8000;
                3: word[15:0] = 16'h7fff;
                default: ;
            endcase
            add = $urandom;
            sym = tgt - add;
            if (i == 5)
                add = add + 1;
            send_request(REQ_HI16, word, $urandom, sym, add);
        end
        // Store is full: this HI16 is dropped with an overflow status.
        send_request(REQ_HI16, 32'hffff_ffff, 32'hdead_beec, 32'hffff_ffff, 32'sh7fff_ffff);
        // Drain all sixteen entries; negative low half on the LO16 word.
        send_request(REQ_LO16, 32'h2403_8000, 32'h0040_0010, tgt, 32'sh0000_0000);

        // Carry out of bit 15 into the upper half.
        send_request(REQ_HI16, 32'hffff_ffff, 32'h0040_0100, 32'h0000_7fff, 32'sh0000_0000);
        send_request(REQ_LO16, 32'h0000_7fff, 32'h0040_0104, 32'h0000_7fff, 32'sh0000_0000);

        // Quiet the sender until all of the directed results are out.
        hold_until_drained();

        // Random part: mostly HI16 runs closed by a LO16 of the same target.
        while (sent_count < 326)
        begin
            send_burst = ($urandom_range(0, 5) == 0);
            recv_burst = ($urandom_range(0, 5) == 0);
            pick = $urandom_range(0, 9);
            if (pick < 7)
            begin
                // A few long runs reach the full store and overflow.
                n   = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 18)
                                                  : $urandom_range(0, 4);
                tgt = $urandom;
                for (int i = 0; i < n; i++)
                begin
                    sym = $urandom;
                    add = tgt - sym;
                    if ($urandom_range(0, 7) == 0)
                        add = $urandom;
                    send_request(REQ_HI16, $urandom, $urandom, sym, add);
                end
                sym = $urandom;
                add = tgt - sym;
                if ($urandom_range(0, 5) == 0)
                    add = $urandom;
                send_request(REQ_LO16, $urandom, $urandom, sym, add);
            end
            else
            begin
                // Noise: any kind, any content.
                send_request(req_kind_t'($urandom_range(0, 1)), $urandom, $urandom,
                             $urandom, $urandom);
            end
            if ($urandom_range(0, 11) == 0)
                hold_until_drained();
        end

        send_burst = 1'b0;
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() != 0) @(posedge clk);
        // Run on so that a stray extra result would still be caught.
        repeat (30) @(posedge clk);

        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire

FILE: mips_hi_lo_reloc_patcher_unit.f
+incdir+rtl
rtl/mhlr_pkg.sv
rtl/mhlr_front.sv
rtl/mhlr_cmd_fifo.sv
rtl/mhlr_back.sv
rtl/mips_hi_lo_reloc_patcher_unit.sv
verif/tb.sv
